FILE: design/pair_force_accumulator_core_assert.svh
// Assertion macros for the pair force accumulator checker.
`ifndef PAIR_FORCE_ACCUMULATOR_CORE_ASSERT_SVH
`define PAIR_FORCE_ACCUMULATOR_CORE_ASSERT_SVH

// Same-cycle implication, sampled on clk and disabled while rst_n is low.
`define PFA_CHK_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pair force accumulator check failed");

// Next-cycle implication, sampled on clk and disabled while rst_n is low.
`define PFA_CHK_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pair force accumulator check failed");

`endif

FILE: design/pfa_pkg.sv
// Shared types and constants of the pair force accumulator.
`timescale 1ns / 1ps
package pfa_pkg;

  localparam int unsigned CFG_AW = 4;
  localparam int unsigned CFG_DW = 32;
  localparam int unsigned REG_W = 31;
  localparam int unsigned R2_W = 41;
  localparam int unsigned DIV_STEPS = 64;
  localparam int unsigned DIV_CW = 6;
  localparam logic [63:0] Q_ONE = 64'h0000_0001_0000_0000;

  typedef enum logic [1:0] {
    REG_CONTACT_RADIUS_SQ = 2'd0,
    REG_MIN_DISTANCE_SQ   = 2'd1,
    REG_STRENGTH          = 2'd2
  } reg_idx_t;

  typedef struct packed {
    logic [REG_W-1:0] contact_radius_sq;
    logic [REG_W-1:0] min_distance_sq;
    logic [REG_W-1:0] strength;
  } cfg_t;

  typedef enum logic [3:0] {
    OP_NONE, OP_LOAD, OP_MSET, OP_MSTEP, OP_MEND, OP_DINIT, OP_DSTEP, OP_DEND,
    OP_KSAT, OP_ADD, OP_EMIT
  } op_t;

  typedef enum logic [2:0] {
    MS_SQ, MS_D2SQ, MS_D6, MS_D12, MS_T, MS_SX, MS_SY
  } msel_t;

  typedef struct packed {
    op_t        op;
    msel_t      msel;
    logic [1:0] step;
    logic       div_k;
  } cmd_t;

  typedef struct packed {
    logic r2_zero;
    logic k_skip;
    logic mul_ov;
    logic div_ovf;
    logic out_busy;
    logic last;
  } stat_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_MSET, ST_MSTEP, ST_MWAIT, ST_MEND, ST_CHK_R2, ST_DINIT, ST_DSTEP,
    ST_DEND, ST_CHK_D2, ST_CHK_T, ST_KSAT, ST_ADD, ST_DONE
  } state_t;

endpackage

FILE: design/pfa_if.sv
// Stream interfaces for pair items and force results.
`timescale 1ns / 1ps
interface pfa_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] target_x;
  logic signed [31:0] target_y;
  logic signed [31:0] neighbor_x;
  logic signed [31:0] neighbor_y;
  logic               first_pair;
  logic               last_pair;

  modport source (output valid, target_x, target_y, neighbor_x, neighbor_y, first_pair,
                  last_pair, input ready);
  modport sink (input valid, target_x, target_y, neighbor_x, neighbor_y, first_pair,
                last_pair, output ready);
endinterface

interface pfa_out_if;
  logic               valid;
  logic               ready;
  logic signed [63:0] force_x;
  logic signed [63:0] force_y;
  logic               saturated;

  modport source (output valid, force_x, force_y, saturated, input ready);
  modport sink (input valid, force_x, force_y, saturated, output ready);
endinterface

FILE: design/pfa_cfg_regs.sv
// Configuration register bank behind the APB-style port.
`timescale 1ns / 1ps
module pfa_cfg_regs (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [pfa_pkg::CFG_AW-1:0] paddr,
  input  logic [pfa_pkg::CFG_DW-1:0] pwdata,
  output logic [pfa_pkg::CFG_DW-1:0] prdata,
  output logic                        pready,
  output pfa_pkg::cfg_t               cfg
);
  import pfa_pkg::*;

  cfg_t     cfg_r;
  reg_idx_t idx;
  logic     wr_en;

  assign idx    = reg_idx_t'(paddr[3:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (wr_en) begin
      case (idx)
        REG_CONTACT_RADIUS_SQ: cfg_r.contact_radius_sq <= pwdata[REG_W-1:0];
        REG_MIN_DISTANCE_SQ:   cfg_r.min_distance_sq   <= pwdata[REG_W-1:0];
        REG_STRENGTH:          cfg_r.strength          <= pwdata[REG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_CONTACT_RADIUS_SQ: prdata = {1'b0, cfg_r.contact_radius_sq};
      REG_MIN_DISTANCE_SQ:   prdata = {1'b0, cfg_r.min_distance_sq};
      REG_STRENGTH:          prdata = {1'b0, cfg_r.strength};
      default:               prdata = '0;
    endcase
  end
endmodule

FILE: design/pfa_ctrl.sv
// Controller state machine that sequences the multiplier and divider steps.
`timescale 1ns / 1ps
module pfa_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  pfa_pkg::stat_t stat,
  output pfa_pkg::cmd_t  cmd
);
  import pfa_pkg::*;

  localparam logic [DIV_CW-1:0] DIV_LAST = DIV_CW'(DIV_STEPS - 1);

  state_t            state_r, state_nxt;
  msel_t             msel_r, msel_nxt;
  logic              div_k_r, div_k_nxt;
  logic [DIV_CW-1:0] cnt_r, cnt_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      msel_r  <= MS_SQ;
      div_k_r <= 1'b0;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      msel_r  <= msel_nxt;
      div_k_r <= div_k_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    msel_nxt  = msel_r;
    div_k_nxt = div_k_r;
    cnt_nxt   = cnt_r;
    in_ready  = 1'b0;
    cmd.op    = OP_NONE;
    cmd.msel  = msel_r;
    cmd.step  = cnt_r[1:0];
    cmd.div_k = div_k_r;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.op    = OP_LOAD;
          msel_nxt  = MS_SQ;
          state_nxt = ST_MSET;
        end
      end
      ST_MSET: begin
        cmd.op    = OP_MSET;
        cnt_nxt   = '0;
        state_nxt = ST_MSTEP;
      end
      ST_MSTEP: begin
        cmd.op  = OP_MSTEP;
        cnt_nxt = cnt_r + 1'b1;
        if ((msel_r == MS_SQ) ? (cnt_r[1:0] == 2'd1) : (cnt_r[1:0] == 2'd3)) begin
          state_nxt = ST_MWAIT;
        end
      end
      ST_MWAIT: state_nxt = ST_MEND;
      ST_MEND: begin
        cmd.op = OP_MEND;
        unique case (msel_r)
          MS_SQ:   state_nxt = ST_CHK_R2;
          MS_D2SQ: begin
            msel_nxt  = MS_D6;
            state_nxt = ST_MSET;
          end
          MS_D6: begin
            msel_nxt  = MS_D12;
            state_nxt = ST_MSET;
          end
          MS_D12: begin
            msel_nxt  = MS_T;
            state_nxt = ST_MSET;
          end
          MS_T:         state_nxt = ST_CHK_T;
          MS_SX, MS_SY: state_nxt = ST_ADD;
          default:      state_nxt = ST_IDLE;
        endcase
      end
      ST_CHK_R2: begin
        if (stat.r2_zero) begin
          msel_nxt  = MS_SX;
          state_nxt = ST_MSET;
        end else begin
          div_k_nxt = 1'b0;
          state_nxt = ST_DINIT;
        end
      end
      ST_DINIT: begin
        cmd.op    = OP_DINIT;
        cnt_nxt   = '0;
        state_nxt = ST_DSTEP;
      end
      ST_DSTEP: begin
        cmd.op  = OP_DSTEP;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == DIV_LAST) begin
          state_nxt = ST_DEND;
        end
      end
      ST_DEND: begin
        cmd.op = OP_DEND;
        if (div_k_r) begin
          msel_nxt  = MS_SX;
          state_nxt = ST_MSET;
        end else begin
          state_nxt = ST_CHK_D2;
        end
      end
      ST_CHK_D2: begin
        msel_nxt  = stat.k_skip ? MS_SX : MS_D2SQ;
        state_nxt = ST_MSET;
      end
      ST_CHK_T: begin
        if (stat.mul_ov || stat.div_ovf) begin
          state_nxt = ST_KSAT;
        end else begin
          div_k_nxt = 1'b1;
          state_nxt = ST_DINIT;
        end
      end
      ST_KSAT: begin
        cmd.op    = OP_KSAT;
        msel_nxt  = MS_SX;
        state_nxt = ST_MSET;
      end
      ST_ADD: begin
        cmd.op = OP_ADD;
        if (msel_r == MS_SX) begin
          msel_nxt  = MS_SY;
          state_nxt = ST_MSET;
        end else begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!stat.last) begin
          state_nxt = ST_IDLE;
        end else if (!stat.out_busy) begin
          cmd.op    = OP_EMIT;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end
endmodule

FILE: design/pfa_datapath.sv
// Datapath with a shared 32x32 multiplier, a radix-2 divider and the force sums.
`timescale 1ns / 1ps
module pfa_datapath (
  input  logic               clk,
  input  logic               rst_n,
  input  pfa_pkg::cmd_t      cmd,
  output pfa_pkg::stat_t     stat,
  input  pfa_pkg::cfg_t      cfg,
  input  logic signed [31:0] target_x,
  input  logic signed [31:0] target_y,
  input  logic signed [31:0] neighbor_x,
  input  logic signed [31:0] neighbor_y,
  input  logic               first_pair,
  input  logic               last_pair,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [63:0] force_x,
  output logic signed [63:0] force_y,
  output logic               saturated
);
  import pfa_pkg::*;

  logic [31:0]      ax_r, ay_r;
  logic             sx_neg_r, sy_neg_r, last_r;
  logic [R2_W-1:0]  r2_r;
  logic [63:0]      d2_r, d6_r, res_r, k_r;
  logic             ov_r, sq_r;
  logic [63:0]      a_r, b_r;
  logic [63:0]      pp_r;
  logic [1:0]       pp_sh_r;
  logic             pp_vld_r;
  logic [127:0]     acc_r;
  logic [R2_W-1:0]  rem_r;
  logic [63:0]      num_r, quo_r;
  logic [63:0]      term_r;
  logic [63:0]      sum_x_r, sum_y_r;
  logic             sat_r;
  logic             out_valid_r;
  logic [63:0]      force_x_r, force_y_r;
  logic             saturated_r;

  logic [32:0]      dx, dy, dx_neg, dy_neg;
  logic [31:0]      mul_a, mul_b;
  logic [1:0]       mul_sh;
  logic [63:0]      pp_nxt;
  logic [127:0]     pp_ext;
  logic             q_ovf;
  logic [63:0]      qres;
  logic [R2_W-1:0]  r2_sum, min_ext, r2_cl;
  logic             s_ovf, s_neg;
  logic [63:0]      s_mag, term;
  logic [63:0]      diff;
  logic [R2_W:0]    remsh, div_sub;
  logic             div_ge;
  logic [63:0]      sum_sel, add_s, add_res;
  logic             add_pos_ovf, add_neg_ovf;

  assign dx     = {target_x[31], target_x} - {neighbor_x[31], neighbor_x};
  assign dy     = {target_y[31], target_y} - {neighbor_y[31], neighbor_y};
  assign dx_neg = -dx;
  assign dy_neg = -dy;

  always_comb begin
    if (sq_r) begin
      mul_a  = cmd.step[0] ? b_r[31:0] : a_r[31:0];
      mul_b  = mul_a;
      mul_sh = 2'd0;
    end else begin
      mul_a  = cmd.step[0] ? a_r[63:32] : a_r[31:0];
      mul_b  = cmd.step[1] ? b_r[63:32] : b_r[31:0];
      mul_sh = {1'b0, cmd.step[0]} + {1'b0, cmd.step[1]};
    end
  end

  assign pp_nxt = mul_a * mul_b;

  always_comb begin
    unique case (pp_sh_r)
      2'd0:    pp_ext = {64'd0, pp_r};
      2'd1:    pp_ext = {32'd0, pp_r, 32'd0};
      2'd2:    pp_ext = {pp_r, 64'd0};
      default: pp_ext = '0;
    endcase
  end

  assign q_ovf   = |acc_r[127:96];
  assign qres    = q_ovf ? '1 : acc_r[95:32];
  assign r2_sum  = acc_r[64:24];
  assign min_ext = {{(R2_W - REG_W){1'b0}}, cfg.min_distance_sq};
  assign r2_cl   = (r2_sum < min_ext) ? min_ext : r2_sum;
  assign s_ovf   = |acc_r[127:87];
  assign s_mag   = s_ovf ? {1'b0, {63{1'b1}}} : {1'b0, acc_r[86:24]};
  assign s_neg   = (cmd.msel == MS_SY) ? sy_neg_r : sx_neg_r;
  assign term    = s_neg ? -s_mag : s_mag;
  assign diff    = (res_r > d6_r) ? (res_r - d6_r) : 64'd0;

  assign remsh   = {rem_r, num_r[63]};
  assign div_sub = remsh - {1'b0, r2_r};
  assign div_ge  = remsh >= {1'b0, r2_r};

  assign sum_sel     = (cmd.msel == MS_SX) ? sum_x_r : sum_y_r;
  assign add_s       = sum_sel + term_r;
  assign add_pos_ovf = !sum_sel[63] && !term_r[63] && add_s[63];
  assign add_neg_ovf = sum_sel[63] && term_r[63] && !add_s[63];

  always_comb begin
    if (add_pos_ovf) begin
      add_res = {1'b0, {63{1'b1}}};
    end else if (add_neg_ovf) begin
      add_res = {1'b1, 63'd0};
    end else begin
      add_res = add_s;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_x_r     <= '0;
      sum_y_r     <= '0;
      sat_r       <= 1'b0;
      out_valid_r <= 1'b0;
      pp_vld_r    <= 1'b0;
    end else begin
      pp_vld_r <= (cmd.op == OP_MSTEP);
      if (cmd.op == OP_LOAD && first_pair) begin
        sum_x_r <= '0;
        sum_y_r <= '0;
        sat_r   <= 1'b0;
      end
      if (cmd.op == OP_MEND && (cmd.msel == MS_SX || cmd.msel == MS_SY) && s_ovf) begin
        sat_r <= 1'b1;
      end
      if (cmd.op == OP_KSAT) begin
        sat_r <= 1'b1;
      end
      if (cmd.op == OP_ADD) begin
        if (cmd.msel == MS_SX) begin
          sum_x_r <= add_res;
        end else begin
          sum_y_r <= add_res;
        end
        if (add_pos_ovf || add_neg_ovf) begin
          sat_r <= 1'b1;
        end
      end
      if (cmd.op == OP_EMIT) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    pp_r    <= pp_nxt;
    pp_sh_r <= mul_sh;
    if (cmd.op == OP_MSET) begin
      acc_r <= '0;
    end else if (pp_vld_r) begin
      acc_r <= acc_r + pp_ext;
    end
    unique case (cmd.op)
      OP_LOAD: begin
        ax_r     <= dx[32] ? dx_neg[31:0] : dx[31:0];
        ay_r     <= dy[32] ? dy_neg[31:0] : dy[31:0];
        sx_neg_r <= dx[32];
        sy_neg_r <= dy[32];
        last_r   <= last_pair;
        ov_r     <= 1'b0;
        k_r      <= '0;
      end
      OP_MSET: begin
        sq_r <= (cmd.msel == MS_SQ);
        unique case (cmd.msel)
          MS_SQ: begin
            a_r <= {32'd0, ax_r};
            b_r <= {32'd0, ay_r};
          end
          MS_D2SQ: begin
            a_r <= d2_r;
            b_r <= d2_r;
          end
          MS_D6: begin
            a_r <= res_r;
            b_r <= d2_r;
          end
          MS_D12: begin
            a_r <= res_r;
            b_r <= res_r;
          end
          MS_T: begin
            a_r <= {25'd0, cfg.strength, 8'd0};
            b_r <= diff;
          end
          MS_SX: begin
            a_r <= {32'd0, ax_r};
            b_r <= k_r;
          end
          MS_SY: begin
            a_r <= {32'd0, ay_r};
            b_r <= k_r;
          end
          default: begin
            a_r <= '0;
            b_r <= '0;
          end
        endcase
      end
      OP_MEND: begin
        unique case (cmd.msel)
          MS_SQ: r2_r <= r2_cl;
          MS_D2SQ, MS_D12, MS_T: begin
            res_r <= qres;
            ov_r  <= ov_r | q_ovf;
          end
          MS_D6: begin
            res_r <= qres;
            d6_r  <= qres;
            ov_r  <= ov_r | q_ovf;
          end
          MS_SX, MS_SY: term_r <= term;
          default: ;
        endcase
      end
      OP_DINIT: begin
        quo_r <= '0;
        if (cmd.div_k) begin
          rem_r <= {{(R2_W - 24){1'b0}}, res_r[63:40]};
          num_r <= {res_r[39:0], 24'd0};
        end else begin
          rem_r <= '0;
          num_r <= {1'b0, cfg.contact_radius_sq, 32'd0};
        end
      end
      OP_DSTEP: begin
        rem_r <= div_ge ? div_sub[R2_W-1:0] : remsh[R2_W-1:0];
        quo_r <= {quo_r[62:0], div_ge};
        num_r <= {num_r[62:0], 1'b0};
      end
      OP_DEND: begin
        if (cmd.div_k) begin
          k_r <= quo_r;
        end else begin
          d2_r <= quo_r;
        end
      end
      OP_KSAT: k_r <= '1;
      OP_EMIT: begin
        force_x_r   <= sum_x_r;
        force_y_r   <= sum_y_r;
        saturated_r <= sat_r;
      end
      default: ;
    endcase
  end

  assign stat.r2_zero  = (r2_r == '0);
  assign stat.k_skip   = r2_r[R2_W-1] || (d2_r <= Q_ONE);
  assign stat.mul_ov   = ov_r;
  assign stat.div_ovf  = ({{(R2_W - 24){1'b0}}, res_r[63:40]} >= r2_r);
  assign stat.out_busy = out_valid_r && !out_ready;
  assign stat.last     = last_r;

  assign out_valid = out_valid_r;
  assign force_x   = force_x_r;
  assign force_y   = force_y_r;
  assign saturated = saturated_r;
endmodule

FILE: design/pair_force_accumulator_core.sv
// Top level of the pair force accumulator.
//
//   Channel  Direction  Handshake                      Carries
//   in_s     sink       valid/ready                    one pair and run markers
//   out_s    source     valid/ready                    summed force of a run
//   APB      slave      psel/penable/pwrite, pready=1  three 31-bit registers
//
// A pair's work is shortest when it coincides, longer when it lies outside the radius
// and longest on the full path, which a saturating coefficient shortens. The 64-step
// radix-2 divider, run once for R^2/r^2 and once for the coefficient, and the shared
// 32x32 multiplier, which builds wide products from partial products, set those lengths.
// A new pair is taken once the previous one is finished; a result waiting in the
// output register stalls only the next pair that ends a run.
// Reset is synchronous and clears the sums, the saturation flag and the configuration registers.
`timescale 1ns / 1ps
module pair_force_accumulator_core (
  input  logic                        clk,
  input  logic                        rst_n,
  pfa_in_if.sink                      in_s,
  pfa_out_if.source                   out_s,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [pfa_pkg::CFG_AW-1:0] paddr,
  input  logic [pfa_pkg::CFG_DW-1:0] pwdata,
  output logic [pfa_pkg::CFG_DW-1:0] prdata,
  output logic                        pready
);
  import pfa_pkg::*;

  cfg_t  cfg;
  cmd_t  cmd;
  stat_t stat;
  logic  in_ready;

  assign in_s.ready = in_ready;

  pfa_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  pfa_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_s.valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  pfa_datapath u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .stat       (stat),
    .cfg        (cfg),
    .target_x   (in_s.target_x),
    .target_y   (in_s.target_y),
    .neighbor_x (in_s.neighbor_x),
    .neighbor_y (in_s.neighbor_y),
    .first_pair (in_s.first_pair),
    .last_pair  (in_s.last_pair),
    .out_valid  (out_s.valid),
    .out_ready  (out_s.ready),
    .force_x    (out_s.force_x),
    .force_y    (out_s.force_y),
    .saturated  (out_s.saturated)
  );
endmodule

FILE: design/pfa_checker.sv
// Port-level checker for the pair force accumulator and its bind.
`timescale 1ns / 1ps
`include "pair_force_accumulator_core_assert.svh"
module pfa_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [63:0] force_x,
  input logic [63:0] force_y,
  input logic        saturated
);
  // A stalled result stays offered.
  `PFA_CHK_NEXT(a_out_hold, out_valid && !out_ready, out_valid)
  // A stalled result keeps its value.
  `PFA_CHK_NEXT(a_out_stable, out_valid && !out_ready, $stable(force_x) && $stable(force_y) && $stable(saturated))
  // After a transfer in, the block is busy with that pair.
  `PFA_CHK_NEXT(a_busy_after_in, in_valid && in_ready, !in_ready)
  // A result appears only at the end of a pair's work.
  `PFA_CHK_NOW(a_emit_when_busy, $rose(out_valid), $past(!in_ready))
endmodule

bind pair_force_accumulator_core pfa_checker u_pfa_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_s.valid),
  .in_ready  (in_s.ready),
  .out_valid (out_s.valid),
  .out_ready (out_s.ready),
  .force_x   (out_s.force_x),
  .force_y   (out_s.force_y),
  .saturated (out_s.saturated)
);
